// File: rtl/assert_macros.svh
// Assertion macros shared by the planner RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fnp_pkg.sv
// Package for the fractional-N PLL frequency planner: field widths,
// band limits and the reciprocal constants used for the fixed divisions.
package fnp_pkg;

  localparam int KHZ_W   = 23;
  localparam int SEL_W   = 3;
  localparam int INT_W   = 8;
  localparam int FRAC_W  = 12;
  localparam int WORD_W  = 32;
  localparam int FREQ_W  = 30;
  localparam int REM_W   = 16;
  localparam int BANDS   = 8;

  localparam int MIN_KHZ  = 23500;
  localparam int MAX_KHZ  = 6000000;
  localparam int PFD_KHZ  = 40000;
  localparam int FRAC_MOD = 4000;
  localparam int FRAC_STEP  = PFD_KHZ / FRAC_MOD;
  localparam int FRAC_ROUND = FRAC_STEP / 2;

  // Feedback ratio limits for a VCO of 3 GHz up to 6 GHz.
  localparam int N_MIN = (MAX_KHZ / 2) / PFD_KHZ;
  localparam int N_MAX = (MAX_KHZ - 1) / PFD_KHZ;

  // 40000 = 625 * 2^6, so the quotient is taken from the VCO value
  // shifted right by six and divided by 625 through a reciprocal.
  localparam int PFD_SHIFT    = 6;
  localparam int X_W          = KHZ_W - PFD_SHIFT;
  localparam int DIV625_MUL   = 107375;
  localparam int DIV625_SHIFT = 26;
  localparam int MUL625_W     = 17;

  // Reciprocal for the divide by ten of the rounded remainder.
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;
  localparam int MUL10_W     = 16;

  localparam int SCALE_SHIFT = 7;
  localparam int INT_LSB     = 15;
  localparam int FRAC_LSB    = 3;

  typedef logic [KHZ_W-1:0]  khz_t;
  typedef logic [SEL_W-1:0]  sel_t;
  typedef logic [INT_W-1:0]  int_div_t;
  typedef logic [FRAC_W-1:0] frac_div_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [FREQ_W-1:0] freq_t;

endpackage

// File: rtl/fnp_if.sv
// Valid/ready channel interfaces for the planner's request and result.
// Payload types come from fnp_pkg.
interface fnp_req_if import fnp_pkg::*; ();
  logic valid;
  logic ready;
  khz_t target_khz;

  modport source (output valid, output target_khz, input ready);
  modport sink (input valid, input target_khz, output ready);
endinterface

interface fnp_res_if import fnp_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      out_of_range;
  sel_t      out_div_sel;
  int_div_t  int_div;
  frac_div_t frac_div;
  word_t     divider_word;
  freq_t     achieved_freq;

  modport source (
    output valid, output out_of_range, output out_div_sel, output int_div,
    output frac_div, output divider_word, output achieved_freq, input ready
  );
  modport sink (
    input valid, input out_of_range, input out_div_sel, input int_div,
    input frac_div, input divider_word, input achieved_freq, output ready
  );
endinterface

// File: rtl/frac_n_pll_frequency_planner_unit.sv
// Top level of the fractional-N PLL frequency planner.
// Uses fnp_pkg, the channel interfaces in fnp_if.sv and assert_macros.svh.
//
// A request carries a wanted output frequency in whole kHz; each request
// yields one result, and a new request is taken every cycle while the
// result side is ready. The six registers are the input register, the band
// select, the divide by 40000 on a 17 by 17 bit multiplier, the remainder,
// the divide by ten on a second multiplier, and the output register that
// builds the divider word and achieved frequency.
// Each stage moves up whenever the stage after it is empty or moving, so
// requests keep filling empty stages while a result waits to be taken.
// Requests below 23.5 MHz or at 6 GHz and above give out_of_range with all
// other fields zero.
`include "assert_macros.svh"

module frac_n_pll_frequency_planner_unit import fnp_pkg::*; (
  input logic     clk,
  input logic     rst,
  fnp_req_if.sink   req,
  fnp_res_if.source res
);

  logic v0, v1, v2, v3, v4, v5;
  logic en0, en1, en2, en3, en4, en5;

  khz_t khz0;

  logic oor1;
  sel_t sel1;
  khz_t vco1;

  logic     oor2;
  sel_t     sel2;
  khz_t     vco2;
  int_div_t n2;

  logic             oor3;
  sel_t             sel3;
  int_div_t         n3;
  logic [REM_W-1:0] rem3;

  logic      oor4;
  sel_t      sel4;
  int_div_t  n4;
  frac_div_t frac4;

  logic      oor5;
  sel_t      sel5;
  int_div_t  n5;
  frac_div_t frac5;
  word_t     word5;
  freq_t     freq5;

  logic oor_a;
  sel_t sel_a;
  khz_t vco_a;

  logic [X_W-1:0]          x_b;
  logic [X_W+MUL625_W-1:0] prod_b;
  int_div_t                n_b;

  khz_t             pfd_c;
  logic [REM_W-1:0] rem_c;

  logic [MUL10_W-1:0]         y_d;
  logic [MUL10_W+MUL10_W-1:0] prod_d;
  frac_div_t                  frac_d;

  khz_t  val_e;
  freq_t freq_e;
  word_t word_e;

  assign en5 = !v5 || res.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign req.ready = en0;

  always_comb begin
    oor_a = (khz0 < KHZ_W'(MIN_KHZ)) || (khz0 >= KHZ_W'(MAX_KHZ));
    sel_a = '0;
    for (int d = 0; d < BANDS; d++) begin
      if (khz0 < KHZ_W'(MAX_KHZ >> d)) begin
        sel_a = SEL_W'(d);
      end
    end
    vco_a = khz0 << sel_a;
  end

  always_comb begin
    x_b    = vco1[KHZ_W-1:PFD_SHIFT];
    prod_b = {{MUL625_W{1'b0}}, x_b} * (X_W+MUL625_W)'(DIV625_MUL);
    n_b    = prod_b[DIV625_SHIFT +: INT_W];
  end

  always_comb begin
    pfd_c = {{(KHZ_W-INT_W){1'b0}}, n2} * KHZ_W'(PFD_KHZ);
    rem_c = REM_W'(vco2 - pfd_c);
  end

  always_comb begin
    y_d    = MUL10_W'(rem3) + MUL10_W'(FRAC_ROUND);
    prod_d = {{MUL10_W{1'b0}}, y_d} * (MUL10_W+MUL10_W)'(DIV10_MUL);
    frac_d = prod_d[DIV10_SHIFT +: FRAC_W];
  end

  always_comb begin
    val_e  = ({{(KHZ_W-INT_W){1'b0}}, n4} * KHZ_W'(PFD_KHZ))
           + ({{(KHZ_W-FRAC_W){1'b0}}, frac4} * KHZ_W'(FRAC_STEP));
    freq_e = {val_e, {SCALE_SHIFT{1'b0}}} >> sel4;
    word_e = '0;
    word_e[INT_LSB +: INT_W]   = n4;
    word_e[FRAC_LSB +: FRAC_W] = frac4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en0) v0 <= req.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      khz0 <= req.target_khz;
    end
    if (en1) begin
      oor1 <= oor_a;
      sel1 <= sel_a;
      vco1 <= vco_a;
    end
    if (en2) begin
      oor2 <= oor1;
      sel2 <= sel1;
      vco2 <= vco1;
      n2   <= n_b;
    end
    if (en3) begin
      oor3 <= oor2;
      sel3 <= sel2;
      n3   <= n2;
      rem3 <= rem_c;
    end
    if (en4) begin
      oor4  <= oor3;
      sel4  <= sel3;
      n4    <= n3;
      frac4 <= frac_d;
    end
    if (en5) begin
      oor5 <= oor4;
      if (oor4) begin
        sel5  <= '0;
        n5    <= '0;
        frac5 <= '0;
        word5 <= '0;
        freq5 <= '0;
      end else begin
        sel5  <= sel4;
        n5    <= n4;
        frac5 <= frac4;
        word5 <= word_e;
        freq5 <= freq_e;
      end
    end
  end

  assign res.valid         = v5;
  assign res.out_of_range  = oor5;
  assign res.out_div_sel   = sel5;
  assign res.int_div       = n5;
  assign res.frac_div      = frac5;
  assign res.divider_word  = word5;
  assign res.achieved_freq = freq5;

  `ASSERT_IMPLIES(a_ratio_in_band, res.valid && !res.out_of_range,
    res.int_div >= INT_W'(N_MIN) && res.int_div <= INT_W'(N_MAX) &&
    res.frac_div <= FRAC_W'(FRAC_MOD), "In-band result has a ratio outside the VCO band.")
  `ASSERT_IMPLIES(a_oor_zero, res.valid && res.out_of_range,
    res.out_div_sel == '0 && res.int_div == '0 && res.frac_div == '0 &&
    res.divider_word == '0 && res.achieved_freq == '0, "Out-of-range result has nonzero fields.")
  `ASSERT_NEXT(a_input_hold, v0 && !en1, v0 && $stable(khz0),
    "Held request in the input register was lost or changed.")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for frac_n_pll_frequency_planner_unit.
// Needs fnp_pkg, the channel interfaces in fnp_if.sv and the planner RTL.
module tb_top;
  import fnp_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    khz_t      target_khz;
    logic      out_of_range;
    sel_t      out_div_sel;
    int_div_t  int_div;
    frac_div_t frac_div;
    word_t     divider_word;
    freq_t     achieved_freq;
  } plan_t;

  logic clk;
  logic rst;

  fnp_req_if req_ch ();
  fnp_res_if res_ch ();

  frac_n_pll_frequency_planner_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  khz_t  pending_khz[$];
  plan_t plan_q[$];
  int    total_items;
  int    sent_count;
  int    quiet_cycles;
  int    errors;
  int    phase;
  int    hold_left;
  bit    hold_done;
  bit    req_fire;

  always #5 clk = ~clk;

  function automatic plan_t plan_frequency(khz_t khz);
    plan_t r;
    longint unsigned vco, n, rem, frac, achieved;
    int sel;
    r = '0;
    r.target_khz = khz;
    if (khz < MIN_KHZ || khz >= MAX_KHZ) begin
      r.out_of_range = 1'b1;
      return r;
    end
    sel = 0;
    for (int d = BANDS - 1; d >= 0; d--) begin
      if (khz < (MAX_KHZ >> d)) begin
        sel = d;
        break;
      end
    end
    vco = longint'(khz) << sel;
    n = vco / PFD_KHZ;
    rem = vco % PFD_KHZ;
    frac = (rem + FRAC_ROUND) / FRAC_STEP;
    achieved = ((PFD_KHZ * n + FRAC_STEP * frac) << SCALE_SHIFT) >> sel;
    r.out_div_sel = sel_t'(sel);
    r.int_div = int_div_t'(n);
    r.frac_div = frac_div_t'(frac);
    r.divider_word = word_t'(((n & 64'hFFFF) << INT_LSB) | ((frac & 64'hFFF) << FRAC_LSB));
    r.achieved_freq = freq_t'(achieved);
    return r;
  endfunction

  function automatic khz_t random_target();
    int pick, d, lo, hi;
    int edges[8];
    pick = $urandom_range(99);
    if (pick < 8) begin
      return khz_t'($urandom);
    end else if (pick < 12) begin
      return khz_t'($urandom_range(0, MIN_KHZ - 1));
    end else if (pick < 22) begin
      d = $urandom_range(0, BANDS);
      lo = (d == BANDS) ? MIN_KHZ : (MAX_KHZ >> d);
      return khz_t'(lo + $urandom_range(0, 6) - 3);
    end else if (pick < 30) begin
      edges = '{39995, 39996, 39997, 39998, 39999, 4, 5, 0};
      return khz_t'($urandom_range(N_MIN, N_MAX) * PFD_KHZ + edges[$urandom_range(0, 7)]);
    end
    d = $urandom_range(0, BANDS - 1);
    lo = MAX_KHZ >> (d + 1);
    if (lo < MIN_KHZ) lo = MIN_KHZ;
    hi = (MAX_KHZ >> d) - 1;
    return khz_t'($urandom_range(lo, hi));
  endfunction

  task automatic report(string msg);
    if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, khz_t khz, longint unsigned got,
                             longint unsigned want);
    if (got !== want)
      report($sformatf("target %0d kHz, %s got %0d expected %0d", khz, name, got, want));
  endtask

  always_comb begin
    if (sent_count < total_items / 3) phase = 0;
    else if (sent_count < 2 * total_items / 3) phase = 1;
    else phase = 2;
  end

  // Request driver.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (pending_khz.size() != 0 &&
          $urandom_range(99) >= (phase == 0 ? 24 : (phase == 1 ? 63 : 0))) begin
        req_ch.valid <= 1'b1;
        req_ch.target_khz <= pending_khz.pop_front();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side ready, including one long hold-off while requests keep coming.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && phase == 2 && sent_count >= 2 * total_items / 3 + 50) begin
      res_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      res_ch.ready <= $urandom_range(99) >= (phase == 0 ? 63 : (phase == 1 ? 24 : 0));
    end
  end

  // Monitor, checker and watchdog.
  always @(posedge clk) begin
    plan_t want;
    bit res_fire;
    req_fire = !rst && req_ch.valid && req_ch.ready;
    res_fire = !rst && res_ch.valid && res_ch.ready;
    if (req_fire) begin
      plan_q.push_back(plan_frequency(req_ch.target_khz));
      sent_count++;
    end
    if (res_fire) begin
      if (plan_q.size() == 0) begin
        report("result transfer with no request outstanding");
      end else begin
        want = plan_q.pop_front();
        check_field("out_of_range", want.target_khz, res_ch.out_of_range, want.out_of_range);
        check_field("out_div_sel", want.target_khz, res_ch.out_div_sel, want.out_div_sel);
        check_field("int_div", want.target_khz, res_ch.int_div, want.int_div);
        check_field("frac_div", want.target_khz, res_ch.frac_div, want.frac_div);
        check_field("divider_word", want.target_khz, res_ch.divider_word, want.divider_word);
        check_field("achieved_freq", want.target_khz, res_ch.achieved_freq,
                    want.achieved_freq);
      end
    end
    if (req_fire || res_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL frac_n_pll_frequency_planner_unit");
        $finish;
      end
    end
  end

  initial begin
    khz_t directed[$];
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.target_khz = '0;
    res_ch.ready = 1'b0;
    sent_count = 0;
    quiet_cycles = 0;
    errors = 0;
    hold_left = 0;
    hold_done = 1'b0;
    req_fire = 1'b0;

    // Band edges, both ends of the field, and remainders that round to a full
    // step or sit right at the half-step rounding point.
    directed = '{0, 1, 23499, 23500, 46874, 46875, 93749, 93750, 187499, 187500,
                 374999, 375000, 749999, 750000, 1499999, 1500000, 2999999,
                 3000000, 3039995, 3039999, 3040004, 3040005, 5999999, 6000000,
                 8388607};
    foreach (directed[i]) pending_khz.push_back(directed[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_khz.push_back(random_target());
    total_items = pending_khz.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (sent_count < total_items || plan_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS frac_n_pll_frequency_planner_unit");
    end else begin
      $display("FAIL frac_n_pll_frequency_planner_unit");
    end
    $finish;
  end

endmodule
